FILE: sv/nsba_pkg.sv
package nsba_pkg;

    // field widths fixed by the register map and the item formats
    localparam int REG_W   = 11;
    localparam int COORD_W = 11;
    localparam int ORG_W   = 10;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

    // input transaction: a start request or a tick
    typedef struct packed {
        logic               start_req;
        logic [ORG_W-1:0]   src_origin_x;
        logic [ORG_W-1:0]   src_origin_y;
        logic [ORG_W-1:0]   dst_origin_x;
        logic [ORG_W-1:0]   dst_origin_y;
    } t_in;

    // output transaction: one pixel position pair
    typedef struct packed {
        logic               valid_res;
        logic [COORD_W-1:0] out_dst_x;
        logic [COORD_W-1:0] out_dst_y;
        logic [COORD_W-1:0] out_src_x;
        logic [COORD_W-1:0] out_src_y;
        logic               last;
    } t_out;

endpackage

FILE: sv/nsba_div.sv
module nsba_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [nsba_pkg::REG_W-1:0]            i_num,
    input  logic [nsba_pkg::REG_W-1:0]            i_den,
    output logic                                  o_done,
    output logic [nsba_pkg::REG_W+FRAC_BITS-1:0]  o_quot
);

    localparam int RW    = nsba_pkg::REG_W;
    localparam int QW    = RW + FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);

    logic              r_busy;
    logic              r_done;
    logic [QW-1:0]     r_num;
    logic [RW-1:0]     r_rem;
    logic [RW-1:0]     r_den;
    logic [CNT_W-1:0]  r_cnt;

    logic [RW:0]       w_shift;
    logic [RW:0]       w_diff;
    logic              w_ge;

    // one restoring step: bring down the next dividend bit and try the subtract
    assign w_shift = {r_rem, r_num[QW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    // busy and done flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // dividend shifts out as quotient bits shift in, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_num, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= CNT_W'(QW);
        end else if (r_busy) begin
            r_num <= {r_num[QW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[RW-1:0] : w_shift[RW-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

FILE: sv/nearest_stretch_blit_addresser_core.sv
// Nearest-neighbour stretch blit address generator.
// Input channel (i_in_valid / o_in_ready / i_in_data): a transaction with
// start_req set latches the four origins and begins a blit; one with
// start_req clear is a tick that yields the next destination pixel and the
// source pixel copied to it, row-major, with last on the final pixel.
// Output channel (o_out_valid / i_out_ready / o_out_data): one transaction
// per input transaction, held in an output register; valid_res marks a pixel.
// Configuration (i_cfg_we / i_cfg_idx / i_cfg_data): source and destination
// widths and heights, written while the block is idle.
// A tick's result sits in the output register from the cycle after acceptance,
// and a new tick is taken while the previous result drains.
// A start runs the shared restoring divider twice (row then column step),
// one quotient bit a cycle; its result enters the output register when the
// column division ends, and no input is taken while the divisions run.
// Reset clears the sizes to 1, drops any blit and empties the output
// register. While the receiver stalls, the output register holds its
// result and no further input is taken.
module nearest_stretch_blit_addresser_core #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  nsba_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output nsba_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [nsba_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [nsba_pkg::REG_W-1:0]         i_cfg_data
);

    localparam int RW = nsba_pkg::REG_W;
    localparam int CW = nsba_pkg::COORD_W;
    localparam int OW = nsba_pkg::ORG_W;
    localparam int QW = RW + FRAC_BITS;
    localparam int AW = QW + 1;
    localparam int NW = AW - FRAC_BITS;
    localparam logic [AW-1:0] ONE_UNIT  = AW'(1) << FRAC_BITS;
    localparam logic [AW-1:0] FRAC_MASK = ONE_UNIT - AW'(1);

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_DIV_ROW = 3'b010,
        S_DIV_COL = 3'b100
    } t_state;

    // clamp a size register to the working range
    function automatic logic [RW-1:0] f_eff(input logic [RW-1:0] v);
        logic [RW-1:0] r;
        r = v;
        if (r == '0) r = RW'(1);
        if (32'(r) > MAX_DIM) r = RW'(MAX_DIM);
        return r;
    endfunction

    // configuration registers
    logic [RW-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;

    // control state
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_active, n_active;

    // walk state and output payload
    logic [QW-1:0]     r_row_step, n_row_step;
    logic [QW-1:0]     r_col_step, n_col_step;
    logic [AW-1:0]     r_row_accum, n_row_accum;
    logic [AW-1:0]     r_col_accum, n_col_accum;
    logic [CW-1:0]     r_next_row, n_next_row;
    logic [CW-1:0]     r_next_col, n_next_col;
    logic [CW-1:0]     r_cur_col, n_cur_col;
    logic [RW-1:0]     r_col_cnt, n_col_cnt;
    logic [RW-1:0]     r_row_cnt, n_row_cnt;
    logic [OW-1:0]     r_org [4];
    logic [OW-1:0]     n_org [4];
    nsba_pkg::t_out    r_out, n_out;

    // divider interface
    logic              div_start;
    logic [RW-1:0]     div_num, div_den;
    logic              div_done;
    logic [QW-1:0]     div_quot;

    // tick datapath
    logic [RW-1:0]     t_dw, t_dh;
    logic [CW-1:0]     t_row, t_col, t_cur, t_col_next;
    logic [AW-1:0]     t_racc, t_cacc, t_cacc_next;
    logic [NW-1:0]     t_nr, t_nc;
    logic [RW:0]       t_col_inc, t_row_inc;
    logic              t_eol, t_fin;

    logic              in_acc;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    // one shared divider for both increments
    assign div_num = (r_state == S_DIV_ROW) ? f_eff(r_src_w) : f_eff(r_src_h);
    assign div_den = (r_state == S_DIV_ROW) ? f_eff(r_dst_w) : f_eff(r_dst_h);

    nsba_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // store configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RW'(1);
            r_src_h <= RW'(1);
            r_dst_w <= RW'(1);
            r_dst_h <= RW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nsba_pkg::CFG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                nsba_pkg::CFG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                nsba_pkg::CFG_DST_WIDTH:  r_dst_w <= i_cfg_data;
                nsba_pkg::CFG_DST_HEIGHT: r_dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance the walk by one destination pixel
    always_comb begin
        t_dw = f_eff(r_dst_w);
        t_dh = f_eff(r_dst_h);
        t_nr = r_row_accum[AW-1:FRAC_BITS];
        if (r_col_cnt == '0) begin
            t_row  = r_next_row + CW'(t_nr);
            t_racc = r_row_accum & FRAC_MASK;
            t_cacc = ONE_UNIT;
            t_col  = CW'(r_org[0]);
        end else begin
            t_row  = r_next_row;
            t_racc = r_row_accum;
            t_cacc = r_col_accum;
            t_col  = r_next_col;
        end
        t_nc = t_cacc[AW-1:FRAC_BITS];
        if (t_nc != '0) begin
            t_cur      = t_col + CW'(t_nc) - CW'(1);
            t_col_next = t_col + CW'(t_nc);
        end else begin
            t_cur      = r_cur_col;
            t_col_next = t_col;
        end
        t_cacc_next = (t_cacc & FRAC_MASK) + AW'(r_col_step);
        t_col_inc   = {1'b0, r_col_cnt} + (RW+1)'(1);
        t_row_inc   = {1'b0, r_row_cnt} + (RW+1)'(1);
        t_eol       = (t_col_inc >= {1'b0, t_dw});
        t_fin       = t_eol && (t_row_inc >= {1'b0, t_dh});
    end

    // sequencer and next-state selection
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_active    = r_active;
        n_row_step  = r_row_step;
        n_col_step  = r_col_step;
        n_row_accum = r_row_accum;
        n_col_accum = r_col_accum;
        n_next_row  = r_next_row;
        n_next_col  = r_next_col;
        n_cur_col   = r_cur_col;
        n_col_cnt   = r_col_cnt;
        n_row_cnt   = r_row_cnt;
        n_org       = r_org;
        n_out       = r_out;
        div_start   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.start_req) begin
                        n_org[0]    = i_in_data.src_origin_x;
                        n_org[1]    = i_in_data.src_origin_y;
                        n_org[2]    = i_in_data.dst_origin_x;
                        n_org[3]    = i_in_data.dst_origin_y;
                        n_row_accum = ONE_UNIT;
                        n_col_accum = '0;
                        n_next_row  = CW'(i_in_data.src_origin_y);
                        n_next_col  = CW'(i_in_data.src_origin_x);
                        n_cur_col   = '0;
                        n_col_cnt   = '0;
                        n_row_cnt   = '0;
                        n_active    = 1'b1;
                        div_start   = 1'b1;
                        n_state     = S_DIV_ROW;
                    end else if (r_active) begin
                        n_next_row    = t_row;
                        n_next_col    = t_col_next;
                        n_cur_col     = t_cur;
                        n_out_valid   = 1'b1;
                        n_out.valid_res = 1'b1;
                        n_out.out_dst_x = CW'(r_org[2]) + CW'(r_col_cnt);
                        n_out.out_dst_y = CW'(r_org[3]) + CW'(r_row_cnt);
                        n_out.out_src_x = t_cur;
                        n_out.out_src_y = t_row - CW'(1);
                        n_out.last      = t_fin;
                        n_col_accum   = t_cacc_next;
                        n_row_accum   = t_racc;
                        n_col_cnt     = t_col_inc[RW-1:0];
                        if (t_eol) begin
                            n_col_cnt   = '0;
                            n_row_accum = t_racc + AW'(r_row_step);
                            n_row_cnt   = t_row_inc[RW-1:0];
                            if (t_fin) begin
                                n_row_cnt = '0;
                                n_active  = 1'b0;
                            end
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                    end
                end
            end
            S_DIV_ROW: begin
                if (div_done) begin
                    n_row_step = div_quot;
                    div_start  = 1'b1;
                    n_state    = S_DIV_COL;
                end
            end
            S_DIV_COL: begin
                if (div_done) begin
                    n_col_step  = div_quot;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_active    <= n_active;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_row_step  <= n_row_step;
        r_col_step  <= n_col_step;
        r_row_accum <= n_row_accum;
        r_col_accum <= n_col_accum;
        r_next_row  <= n_next_row;
        r_next_col  <= n_next_col;
        r_cur_col   <= n_cur_col;
        r_col_cnt   <= n_col_cnt;
        r_row_cnt   <= n_row_cnt;
        r_org       <= n_org;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // start transaction always enters the row division
    a_start_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.start_req) |=> (r_state == S_DIV_ROW))
        else $error("start did not enter row division");

    // the start result lands in an empty output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV_COL) && div_done) |-> !r_out_valid)
        else $error("output register busy at end of division");

    // an active tick produces a pixel next cycle
    a_tick_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in_data.start_req && r_active) |=>
        (o_out_valid && o_out_data.valid_res))
        else $error("active tick gave no pixel");

    // last only marks a real pixel
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> o_out_data.valid_res)
        else $error("last without pixel");

endmodule

FILE: sim/nsba_blit_checker.sv
`timescale 1ns / 1ps

module nsba_blit_checker #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  nsba_pkg::t_in                  i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  nsba_pkg::t_out                 i_out_data,
    input  logic                           i_cfg_we,
    input  logic [nsba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [nsba_pkg::REG_W-1:0]     i_cfg_data,
    output int                             o_mismatches,
    output int                             o_outstanding
);

    localparam int CW = nsba_pkg::COORD_W;
    localparam logic [27:0] ONE_UNIT  = 28'd1 << FRAC_BITS;
    localparam logic [27:0] FRAC_PART = ONE_UNIT - 28'd1;

    // shadow of the size registers
    logic [nsba_pkg::REG_W-1:0] sz_src_w, sz_src_h, sz_dst_w, sz_dst_h;

    // blit walk state
    logic                       running;
    logic [26:0]                row_inc, col_inc;
    logic [27:0]                row_acc, col_acc;
    logic [19:0]                src_row_next, src_col_next, src_col_cur;
    logic [10:0]                col_cnt, row_cnt;
    logic [nsba_pkg::ORG_W-1:0] org_src_x, org_src_y, org_dst_x, org_dst_y;

    nsba_pkg::t_out expected_pixels [$];
    int             fail_tally = 0;
    int             waiting    = 0;

    assign o_mismatches  = fail_tally;
    assign o_outstanding = waiting;

    // size actually used: zero counts as one, oversize is capped
    function automatic logic [10:0] used_size(input logic [nsba_pkg::REG_W-1:0] v);
        if (v == '0) return 11'd1;
        if (v > MAX_DIM) return 11'(MAX_DIM);
        return 11'(v);
    endfunction

    // advance the walk by one transaction and return the pixel it yields
    function automatic nsba_pkg::t_out next_pixel(input nsba_pkg::t_in item);
        nsba_pkg::t_out px;
        logic [10:0]    dw, dh;
        logic [11:0]    whole;
        px = '0;
        if (item.start_req) begin
            org_src_x    = item.src_origin_x;
            org_src_y    = item.src_origin_y;
            org_dst_x    = item.dst_origin_x;
            org_dst_y    = item.dst_origin_y;
            row_inc      = (27'(used_size(sz_src_h)) << FRAC_BITS) / used_size(sz_dst_h);
            col_inc      = (27'(used_size(sz_src_w)) << FRAC_BITS) / used_size(sz_dst_w);
            row_acc      = ONE_UNIT;
            col_acc      = '0;
            src_row_next = 20'(org_src_y);
            src_col_next = 20'(org_src_x);
            src_col_cur  = '0;
            col_cnt      = '0;
            row_cnt      = '0;
            running      = 1'b1;
            return px;
        end
        if (!running) return px;

        dw = used_size(sz_dst_w);
        dh = used_size(sz_dst_h);

        // new row: step the source row, restart the column walk
        if (col_cnt == '0) begin
            whole        = 12'(row_acc >> FRAC_BITS);
            src_row_next = src_row_next + 20'(whole);
            row_acc      = row_acc & FRAC_PART;
            col_acc      = ONE_UNIT;
            src_col_next = 20'(org_src_x);
        end

        // step over whole source columns, keep the last one passed
        whole = 12'(col_acc >> FRAC_BITS);
        if (whole != '0) begin
            src_col_cur  = src_col_next + 20'(whole) - 20'd1;
            src_col_next = src_col_next + 20'(whole);
            col_acc      = col_acc & FRAC_PART;
        end

        px.valid_res = 1'b1;
        px.out_dst_x = CW'(32'(org_dst_x) + 32'(col_cnt));
        px.out_dst_y = CW'(32'(org_dst_y) + 32'(row_cnt));
        px.out_src_x = CW'(src_col_cur);
        px.out_src_y = CW'(src_row_next - 20'd1);

        col_acc = col_acc + 28'(col_inc);
        col_cnt = col_cnt + 11'd1;
        if (col_cnt >= dw) begin
            col_cnt = '0;
            row_acc = row_acc + 28'(row_inc);
            row_cnt = row_cnt + 11'd1;
            if (row_cnt >= dh) begin
                px.last = 1'b1;
                running = 1'b0;
                row_cnt = '0;
            end
        end
        return px;
    endfunction

    task automatic check_field(input string name, input logic [CW-1:0] want,
                               input logic [CW-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_tally++;
        end
    endtask

    // watch both channels and the register port on every edge
    always @(posedge i_clk) begin : watch
        nsba_pkg::t_out want;
        if (!i_rst_n) begin
            sz_src_w     = 11'd1;
            sz_src_h     = 11'd1;
            sz_dst_w     = 11'd1;
            sz_dst_h     = 11'd1;
            running      = 1'b0;
            row_inc      = '0;
            col_inc      = '0;
            row_acc      = '0;
            col_acc      = '0;
            src_row_next = '0;
            src_col_next = '0;
            src_col_cur  = '0;
            col_cnt      = '0;
            row_cnt      = '0;
            org_src_x    = '0;
            org_src_y    = '0;
            org_dst_x    = '0;
            org_dst_y    = '0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nsba_pkg::CFG_SRC_WIDTH:  sz_src_w = i_cfg_data;
                    nsba_pkg::CFG_SRC_HEIGHT: sz_src_h = i_cfg_data;
                    nsba_pkg::CFG_DST_WIDTH:  sz_dst_w = i_cfg_data;
                    nsba_pkg::CFG_DST_HEIGHT: sz_dst_h = i_cfg_data;
                    default: ;
                endcase
            end

            // compare a delivered transaction with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel transaction delivered with nothing expected");
                    fail_tally++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("valid_res", CW'(want.valid_res),
                                CW'(i_out_data.valid_res));
                    check_field("out_dst_x", want.out_dst_x, i_out_data.out_dst_x);
                    check_field("out_dst_y", want.out_dst_y, i_out_data.out_dst_y);
                    check_field("out_src_x", want.out_src_x, i_out_data.out_src_x);
                    check_field("out_src_y", want.out_src_y, i_out_data.out_src_y);
                    check_field("last", CW'(want.last), CW'(i_out_data.last));
                end
            end

            if (i_in_valid && i_in_ready)
                expected_pixels.push_back(next_pixel(i_in_data));
        end
        waiting = expected_pixels.size();
    end

endmodule

FILE: sim/tb_nearest_stretch_blit_addresser_core.sv
`timescale 1ns / 1ps

module tb_nearest_stretch_blit_addresser_core;

    localparam int DIM_CAP     = 1024;
    localparam int RUN_ITEMS   = 1550;
    localparam int QUIET_FROM  = 1350;
    localparam int HOLD_AT     = 400;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 400000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    nsba_pkg::t_in                  i_in_data;
    logic                           o_out_valid;
    logic                           i_out_ready;
    nsba_pkg::t_out                 o_out_data;
    logic                           i_cfg_we;
    logic [nsba_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [nsba_pkg::REG_W-1:0]     i_cfg_data;

    int mismatches;
    int outstanding;
    int sent_count   = 0;
    int cycle_count  = 0;
    int blit_pixels  = 1;
    bit pacing_on    = 1'b1;
    bit hold_pending = 1'b0;

    nearest_stretch_blit_addresser_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    nsba_blit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_data    (o_out_data),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // abandon the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nearest_stretch_blit_addresser_core verification failed");
            $finish;
        end
    end

    function automatic int used_size(input logic [nsba_pkg::REG_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_CAP) return DIM_CAP;
        return int'(v);
    endfunction

    function automatic logic [nsba_pkg::REG_W-1:0] edge_size();
        case ($urandom_range(0, 3))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd1024;
            default: return 11'd2047;
        endcase
    endfunction

    // present one transaction, with an occasional gap first, and hold it until taken
    task automatic offer(input nsba_pkg::t_in item);
        if (pacing_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        sent_count++;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_start(input logic [nsba_pkg::ORG_W-1:0] sx, sy, dx, dy);
        offer('{1'b1, sx, sy, dx, dy});
    endtask

    // ticks carry random origins, which the block must ignore
    task automatic send_ticks(input int count);
        repeat (count)
            offer('{1'b0, 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom)});
    endtask

    task automatic write_reg(input logic [nsba_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nsba_pkg::REG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_sizes(input logic [nsba_pkg::REG_W-1:0] sw, sh, dw, dh);
        write_reg(nsba_pkg::CFG_SRC_WIDTH, sw);
        write_reg(nsba_pkg::CFG_SRC_HEIGHT, sh);
        write_reg(nsba_pkg::CFG_DST_WIDTH, dw);
        write_reg(nsba_pkg::CFG_DST_HEIGHT, dh);
        i_cfg_we    <= 1'b0;
        blit_pixels  = used_size(dw) * used_size(dh);
    endtask

    // drop valid and wait for every pixel transaction to come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        @(posedge i_clk);
    endtask

    // receiver pacing: bursts of stall, runs of ready, one long hold-off
    initial begin
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (pacing_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        nsba_pkg::t_in              noise_item;
        logic [nsba_pkg::REG_W-1:0] sw, sh, dw, dh;
        int                         mode;
        bit                         hold_done;

        hold_done   = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= nsba_pkg::CFG_SRC_WIDTH;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes: idle tick, single-pixel blit at the far origins, idle tick
        send_ticks(1);
        send_start('1, '1, '1, '1);
        send_ticks(2);
        drain();

        // zero and oversize source sizes, small stretch
        set_sizes(11'd0, 11'd2047, 11'd3, 11'd2);
        send_start('0, '0, '0, '0);
        send_ticks(6);
        drain();

        // widest destination, abandoned part way by a fresh start
        set_sizes(11'd1024, 11'd1, 11'd2047, 11'd0);
        send_start('1, '1, '1, '1);
        send_ticks(5);
        send_start('0, '0, '0, '0);
        send_ticks(2);
        drain();

        // tallest destination, one pixel per row
        set_sizes(11'd2047, 11'd0, 11'd0, 11'd1024);
        send_start(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
        send_ticks(6);
        drain();

        // random phases of well-formed blits with some noise
        while (sent_count < RUN_ITEMS) begin
            if (sent_count > QUIET_FROM)
                pacing_on = 1'b0;

            case ($urandom_range(0, 9))
                0: begin
                    sw = 11'($urandom);
                    sh = 11'($urandom);
                end
                1: begin
                    sw = edge_size();
                    sh = edge_size();
                end
                default: begin
                    sw = 11'($urandom_range(1, 24));
                    sh = 11'($urandom_range(1, 24));
                end
            endcase
            dw = 11'($urandom_range(0, 8));
            dh = 11'($urandom_range(0, 6));
            if ($urandom_range(0, 15) == 0)
                dw = 11'($urandom_range(9, 64));
            set_sizes(sw, sh, dw, dh);

            // carry on a blit left open by the previous phase under the new sizes
            if ($urandom_range(0, 2) == 0)
                send_ticks($urandom_range(1, 4));

            repeat ($urandom_range(1, 3)) begin
                if (!hold_done && sent_count > HOLD_AT) begin
                    hold_pending = 1'b1;
                    hold_done    = 1'b1;
                end
                mode = $urandom_range(0, 9);
                send_start(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
                if (mode < 6) begin
                    send_ticks(blit_pixels + (mode == 0 ? $urandom_range(1, 3) : 0));
                end else if (mode < 8) begin
                    send_ticks($urandom_range(0, blit_pixels - 1));
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        noise_item = '{($urandom_range(0, 3) == 0), 10'($urandom),
                                       10'($urandom), 10'($urandom), 10'($urandom)};
                        offer(noise_item);
                    end
                end
            end
            drain();
        end

        repeat (64) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0)
            $display("nearest_stretch_blit_addresser_core verification clean");
        else
            $display("nearest_stretch_blit_addresser_core verification failed");
        $finish;
    end

endmodule

FILE: nearest_stretch_blit_addresser_core.f
sv/nsba_pkg.sv
sv/nsba_div.sv
sv/nearest_stretch_blit_addresser_core.sv
sim/nsba_blit_checker.sv
sim/tb_nearest_stretch_blit_addresser_core.sv
